/* rtl/pse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int STEP_LIMIT = 100;
    localparam int STEP_W     = 7;
    localparam int VAL_W      = 16;
    localparam int STEP_OUT_W = 8;
    localparam int PERIOD_W   = 30;
    localparam int COUNT_W    = 32;
    localparam int DIV_N      = 30;
    localparam int DIV_D      = 16;
    localparam int DIV_CNT_W  = 5;
    localparam int IN_W       = 24;
    localparam int OUT_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] RATE_SCALE = PERIOD_W'(1000000000);

    // item codes
    localparam logic [1:0] ACT_TICK      = 2'd0;
    localparam logic [1:0] ACT_RECOMPUTE = 2'd1;
    localparam logic [1:0] ACT_LOAD      = 2'd2;

    // sweep modes
    localparam logic [2:0] MODE_OFF      = 3'd0;
    localparam logic [2:0] MODE_UP       = 3'd1;
    localparam logic [2:0] MODE_DN       = 3'd2;
    localparam logic [2:0] MODE_UP_RESET = 3'd3;
    localparam logic [2:0] MODE_DN_RESET = 3'd4;
    localparam logic [2:0] MODE_UP_DN    = 3'd5;
    localparam logic [2:0] MODE_DN_UP    = 3'd6;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_REC,
        ST_FULL_WAIT,
        ST_SPAN_GO,
        ST_SPAN_WAIT,
        ST_SPAN_CHECK,
        ST_PER_WAIT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DIV_FULL,
        DIV_SPAN,
        DIV_PER
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     tick_prep;
        logic     rec_init;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_full;
        logic     latch_delta;
        logic     s_zero;
        logic     s_inc;
        logic     latch_period;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_action;
        logic       rec_skip;
        logic       div_done;
        logic       delta_zero;
        logic       fits;
        logic       s_last;
        logic       out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/pse_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module pse_div
    import pse_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DIV_N-1:0] dividend,
    input  wire logic [DIV_D-1:0] divisor,
    output logic                  done,
    output logic [DIV_N-1:0]      quotient
);

    logic [DIV_D-1:0]     rem_reg, rem_next;
    logic [DIV_N-1:0]     quo_reg, quo_next;
    logic [DIV_D-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D+1:0]     diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // divisor held from the start cycle on
    assign diff = {1'b0, rem_reg, quo_reg[DIV_N-1]} - {2'b00, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_N - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIV_D+1]) begin
                rem_next = diff[DIV_D-1:0];
                quo_next = {quo_reg[DIV_N-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DIV_D-2:0], quo_reg[DIV_N-1]};
                quo_next = {quo_reg[DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/pse_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pse_ctrl
    import pse_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_FULL;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // nothing is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.accept = 1'b1;
                    unique case (status.in_action)
                        ACT_TICK:      state_next = ST_TICK;
                        ACT_RECOMPUTE: state_next = ST_REC;
                        default:       state_next = ST_FINISH;
                    endcase
                end
            end
            ST_TICK: begin
                cmd.tick_prep = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_REC: begin
                cmd.rec_init = 1'b1;
                if (status.rec_skip) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_FULL;
                    state_next    = ST_FULL_WAIT;
                end
            end
            ST_FULL_WAIT: begin
                if (status.div_done) begin
                    cmd.latch_full = 1'b1;
                    state_next     = ST_SPAN_GO;
                end
            end
            ST_SPAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SPAN;
                state_next    = ST_SPAN_WAIT;
            end
            ST_SPAN_WAIT: begin
                if (status.div_done) begin
                    cmd.latch_delta = 1'b1;
                    state_next      = ST_SPAN_CHECK;
                end
            end
            ST_SPAN_CHECK: begin
                if (status.delta_zero) begin
                    cmd.s_zero = 1'b1;
                    state_next = ST_FINISH;
                end else if (status.fits) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_PER;
                    state_next    = ST_PER_WAIT;
                end else begin
                    cmd.s_inc  = 1'b1;
                    state_next = status.s_last ? ST_FINISH : ST_SPAN_GO;
                end
            end
            ST_PER_WAIT: begin
                if (status.div_done) begin
                    cmd.latch_period = 1'b1;
                    state_next       = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/pse_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module pse_datapath
    import pse_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [IN_W-1:0]       s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    input  wire cmd_t                  cmd,
    output status_t                    status
);

    // configuration
    logic [VAL_W-1:0] min_reg, max_reg, rate_reg;
    logic [2:0]       mode_reg;

    // sweep state
    logic [VAL_W-1:0]      cur_reg, cur_next;
    logic [STEP_OUT_W-1:0] step_reg, step_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [COUNT_W-1:0]    te_reg, te_next;
    logic                  halted_reg, halted_next;

    // item and recompute work registers
    logic [1:0]          act_reg;
    logic [VAL_W-1:0]    load_reg;
    logic [VAL_W-1:0]    sum_reg;
    logic [PERIOD_W-1:0] full_reg;
    logic [VAL_W-1:0]    delta_reg;
    logic [STEP_W-1:0]   s_reg, s_next;
    logic                rec_upd_reg;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic                  mode_active, range_bad, step_go, end_hit, step_neg, neg_sel;
    logic                  stepped, ended;
    logic [VAL_W-1:0]      v_fin;
    logic [STEP_OUT_W-1:0] step_mag, step_tick;
    logic [DIV_N-1:0]      div_dividend;
    logic [DIV_D-1:0]      div_divisor;
    logic                  div_done;
    logic [DIV_N-1:0]      div_quotient;

    pse_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        case (cmd.div_sel)
            DIV_SPAN: begin
                div_dividend = DIV_N'(max_reg - min_reg);
                div_divisor  = DIV_D'(s_reg);
            end
            DIV_PER: begin
                div_dividend = full_reg;
                div_divisor  = delta_reg;
            end
            default: begin
                div_dividend = RATE_SCALE;
                div_divisor  = rate_reg;
            end
        endcase
    end

    assign mode_active = (mode_reg != MODE_OFF) && (mode_reg <= MODE_DN_UP);
    assign range_bad   = max_reg < min_reg;
    assign step_neg    = step_reg[STEP_OUT_W-1];

    assign step_go = mode_active && !halted_reg && (rate_reg != '0) && (step_reg != '0)
                     && (te_reg >= COUNT_W'(period_reg));

    assign end_hit = (sum_reg <= min_reg) || (sum_reg >= max_reg)
                     || (step_neg && (sum_reg > cur_reg))
                     || (!step_neg && (sum_reg < cur_reg));

    // new step sign for recompute
    assign neg_sel = (mode_reg == MODE_DN_RESET) || (mode_reg == MODE_DN)
                     || ((mode_reg == MODE_DN_UP) && !step_neg && (step_reg != '0))
                     || ((mode_reg == MODE_UP_DN) && step_neg);
    assign step_mag = {1'b0, s_reg};

    // end handling per mode
    always_comb begin
        v_fin     = sum_reg;
        step_tick = step_reg;
        if (end_hit) begin
            case (mode_reg)
                MODE_UP_DN, MODE_DN_UP: begin
                    v_fin     = step_neg ? min_reg : max_reg;
                    step_tick = -step_reg;
                end
                MODE_UP_RESET: v_fin = min_reg;
                MODE_DN_RESET: v_fin = max_reg;
                MODE_UP:       v_fin = max_reg;
                default:       v_fin = min_reg;
            endcase
        end
    end

    always_comb begin
        cur_next       = cur_reg;
        step_next      = step_reg;
        period_next    = period_reg;
        te_next        = te_reg;
        halted_next    = halted_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        stepped        = 1'b0;
        ended          = 1'b0;

        if (cmd.tick_prep && (te_reg != '1)) begin
            te_next = te_reg + 1'b1;
        end
        if (cmd.rec_init) begin
            s_next = range_bad ? '0 : STEP_W'(1);
        end
        if (cmd.s_zero) begin
            s_next = '0;
        end
        if (cmd.s_inc) begin
            s_next = s_reg + 1'b1;
        end
        if (cmd.latch_period) begin
            period_next = div_quotient;
        end

        if (cmd.commit) begin
            case (act_reg)
                ACT_TICK: begin
                    if (step_go) begin
                        stepped   = 1'b1;
                        ended     = end_hit;
                        te_next   = '0;
                        cur_next  = v_fin;
                        step_next = step_tick;
                        if (end_hit && ((mode_reg == MODE_UP) || (mode_reg == MODE_DN))) begin
                            halted_next = 1'b1;
                        end
                    end
                end
                ACT_RECOMPUTE: begin
                    halted_next = 1'b0;
                    if (rec_upd_reg) begin
                        step_next = neg_sel ? -step_mag : step_mag;
                    end
                end
                ACT_LOAD: cur_next = load_reg;
                default: ;
            endcase
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({step_next, ended, stepped, cur_next});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= '0;
            max_reg       <= '1;
            rate_reg      <= '0;
            mode_reg      <= MODE_OFF;
            cur_reg       <= '0;
            step_reg      <= '0;
            period_reg    <= '0;
            te_reg        <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_MIN:  min_reg  <= cfg_data;
                    REG_MAX:  max_reg  <= cfg_data;
                    REG_RATE: rate_reg <= cfg_data;
                    REG_MODE: mode_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            cur_reg       <= cur_next;
            step_reg      <= step_next;
            period_reg    <= period_next;
            te_reg        <= te_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
        s_reg        <= s_next;
        out_data_reg <= out_data_next;
        if (cmd.accept) begin
            act_reg  <= s_tdata[1:0];
            load_reg <= s_tdata[VAL_W+1:2];
        end
        if (cmd.tick_prep) begin
            sum_reg <= cur_reg + {{(VAL_W-STEP_OUT_W){step_reg[STEP_OUT_W-1]}}, step_reg};
        end
        if (cmd.rec_init) begin
            rec_upd_reg <= mode_active && (rate_reg != '0);
        end
        if (cmd.latch_full) begin
            full_reg <= div_quotient;
        end
        if (cmd.latch_delta) begin
            delta_reg <= div_quotient[VAL_W-1:0];
        end
    end

    assign status.in_action  = s_tdata[1:0];
    assign status.rec_skip   = !mode_active || (rate_reg == '0) || range_bad;
    assign status.div_done   = div_done;
    assign status.delta_zero = delta_reg == '0;
    assign status.fits       = full_reg >= PERIOD_W'(delta_reg);
    assign status.s_last     = s_reg == STEP_W'(STEP_LIMIT - 1);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/parameter_sweep_engine.sv */
// tick: accept, register the stepped sum, commit; load and no-op: accept, commit
// recompute, if not skipped: full-scale division, one span division per tried size, then a
//   period division for the size that fits, all in the shared one-bit-per-cycle divider
// items: one at a time; a commit waits until the result register is free
// reset: synchronous active-low aresetn restores register defaults and clears sweep state
`timescale 1ns / 1ps
`default_nettype none

module parameter_sweep_engine
    import pse_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,  // action[1:0], load_value[17:2], zero pad
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata   // value[15:0], stepped[16],
                                                 // extent_hit[17], step_size[25:18], pad
);

    // command and status between the sequencer and the datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: accepts one transaction, walks the step search, commits the result
    pse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: config registers, sweep state, divider and result register
    pse_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

/* rtl/pse_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pse_checker
    import pse_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // an end can only be reported on a step
    a_end_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[17] && !m_tdata[16]))
        else $error("end reported without a step");

    // step magnitude never exceeds the limit
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[25:18]) <= STEP_LIMIT)
                      && ($signed(m_tdata[25:18]) >= -STEP_LIMIT)))
        else $error("step size out of range");

    // one item in flight: input is not taken in the cycle right after a transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind parameter_sweep_engine pse_checker u_pse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* verif/parameter_sweep_engine_tb.sv */
`timescale 1ns / 1ps

module parameter_sweep_engine_tb;
    import pse_pkg::*;

    // unused item code and the reserved sweep mode, both treated as no-ops
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam logic [2:0] MODE_RESERVED  = 3'd7;

    localparam int unsigned FULL_SCALE    = 32'd1000000000;
    localparam int          RANDOM_ITEMS  = 1150;
    localparam int          STALL_LIMIT   = 20000;
    localparam int          IDLE_GAP      = 8;
    localparam int          TAIL_CYCLES   = 40;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] load_value;
    } sweep_item_t;

    typedef struct packed {
        logic [15:0] value;
        logic        stepped;
        logic        extent_hit;
        logic [7:0]  step_size;
    } sweep_result_t;

    // clock, reset, and all block inputs start at known values
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata  = '0;  // action[1:0], load_value[17:2], zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;        // value[15:0], stepped[16],
                                           // extent_hit[17], step_size[25:18], pad

    parameter_sweep_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // sweep predictor: its own copy of registers and sweep state
    // ------------------------------------------------------------------
    logic [15:0]        min_q, max_q, rate_q;
    logic [2:0]         mode_q;
    logic [15:0]        cur_val;
    logic signed [7:0]  step_q;
    logic [PERIOD_W-1:0] period_q;
    logic [31:0]        elapsed_q;
    logic               halted_q;

    function automatic bit mode_active();
        return mode_q >= MODE_UP && mode_q <= MODE_DN_UP;
    endfunction

    // smallest step magnitude whose period is at least one tick, then signed
    function automatic void recompute_step();
        int          prev_step, s;
        int unsigned span, full, delta;
        bit          found;
        halted_q = 1'b0;
        if (!mode_active() || rate_q == 16'd0) return;
        prev_step = step_q;
        s         = 1;
        found     = 1'b0;
        if (max_q < min_q) begin
            s = 0;  // inverted range disables stepping
        end else begin
            span = max_q - min_q;
            full = FULL_SCALE / rate_q;
            while (s < STEP_LIMIT && !found) begin
                delta = span / s;
                if (delta == 0) begin
                    s     = 0;  // zero range
                    found = 1'b1;
                end else if (full >= delta) begin
                    period_q = PERIOD_W'(full / delta);
                    found    = 1'b1;
                end else begin
                    s++;
                end
            end
            // search exhausted: step stays at the limit, period keeps old value
        end
        if (mode_q == MODE_DN_RESET || mode_q == MODE_DN ||
            (mode_q == MODE_DN_UP && prev_step > 0) ||
            (mode_q == MODE_UP_DN && prev_step < 0))
            s = -s;
        step_q = 8'(s);
    endfunction

    function automatic void advance_tick(output bit stepped, output bit ended);
        logic [15:0] prev, v;
        bit          hit;
        stepped = 1'b0;
        ended   = 1'b0;
        if (elapsed_q != 32'hFFFF_FFFF) elapsed_q++;
        if (!mode_active() || halted_q || rate_q == 16'd0 || step_q == 8'sd0) return;
        if (elapsed_q < 32'(period_q)) return;
        elapsed_q = '0;
        stepped   = 1'b1;
        prev      = cur_val;
        v         = prev + {{8{step_q[7]}}, step_q};
        // extent reached, or the sum wrapped against the step direction
        hit = v <= min_q || v >= max_q ||
              (step_q < 0 && v > prev) || (step_q > 0 && v < prev);
        if (hit) begin
            case (mode_q)
                MODE_UP_DN, MODE_DN_UP: begin
                    v      = (step_q < 0) ? min_q : max_q;
                    step_q = -step_q;
                end
                MODE_UP_RESET: v = min_q;
                MODE_DN_RESET: v = max_q;
                MODE_UP: begin
                    v        = max_q;
                    halted_q = 1'b1;
                end
                default: begin
                    v        = min_q;
                    halted_q = 1'b1;
                end
            endcase
        end
        cur_val = v;
        ended   = hit;
    endfunction

    function automatic sweep_result_t predict_sweep(input sweep_item_t it);
        sweep_result_t r;
        bit            st, en;
        st = 1'b0;
        en = 1'b0;
        case (it.action)
            ACT_TICK:      advance_tick(st, en);
            ACT_RECOMPUTE: recompute_step();
            ACT_LOAD:      cur_val = it.load_value;  // stored unclamped
            default: ;
        endcase
        r.value      = cur_val;
        r.stepped    = st;
        r.extent_hit = en;
        r.step_size  = step_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // shared stimulus and scoreboard state
    // ------------------------------------------------------------------
    sweep_item_t   sweep_items_q[$];
    sweep_result_t expected_results_q[$];
    sweep_item_t   held_item;
    int            tx_idle_pct = 20;
    int            rx_idle_pct = 83;
    int            items_queued = 0;
    int            error_count = 0;
    int            results_checked = 0;
    int            steps_seen = 0;
    int            ends_seen = 0;
    int            recomputes_seen = 0;
    int            settings_used = 0;
    int            stall_cycles = 0;

    // input driver: holds tdata/tvalid until the transaction completes
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results_q.push_back(predict_sweep(held_item));
                if (held_item.action == ACT_RECOMPUTE) recomputes_seen++;
            end
            if (!s_tvalid || s_tready) begin
                if (sweep_items_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    held_item = sweep_items_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= IN_W'({held_item.load_value, held_item.action});
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random backpressure, in-order field compare
    always @(posedge aclk) begin
        sweep_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (m_tvalid && m_tready) begin
                if (expected_results_q.size() == 0) begin
                    $error("result transaction with no expectation pending: tdata %h",
                           m_tdata);
                    error_count++;
                end else begin
                    want = expected_results_q.pop_front();
                    results_checked++;
                    if (want.stepped) steps_seen++;
                    if (want.extent_hit) ends_seen++;
                    if (m_tdata[15:0] !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, m_tdata[15:0]);
                        error_count++;
                    end
                    if (m_tdata[16] !== want.stepped) begin
                        $error("stepped: expected %0d, got %0d", want.stepped, m_tdata[16]);
                        error_count++;
                    end
                    if (m_tdata[17] !== want.extent_hit) begin
                        $error("extent_hit: expected %0d, got %0d",
                               want.extent_hit, m_tdata[17]);
                        error_count++;
                    end
                    if (m_tdata[25:18] !== want.step_size) begin
                        $error("step_size: expected %0d, got %0d",
                               $signed(want.step_size), $signed(m_tdata[25:18]));
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("parameter_sweep_engine regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(input logic [1:0] action, input logic [15:0] load);
        sweep_item_t it;
        it.action     = action;
        it.load_value = load;
        sweep_items_q.push_back(it);
        items_queued++;
    endfunction

    // mostly ticks, some loads, a few no-ops and rare (slow) recomputes
    function automatic void push_mixed_item(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 86)
            push_item(ACT_TICK, 16'($urandom));
        else if (r < 94)
            push_item(ACT_LOAD, ($urandom_range(3) != 0) ? 16'($urandom_range(lo, hi))
                                                        : 16'($urandom));
        else if (r < 97)
            push_item(ACT_UNUSED, 16'($urandom));
        else
            push_item(ACT_RECOMPUTE, 16'($urandom));
    endfunction

    function automatic logic [15:0] edge_u16();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // block is idle once no item is queued or offered and every result is back
    task automatic wait_idle();
        while (sweep_items_q.size() != 0 || s_tvalid || expected_results_q.size() != 0)
            @(negedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        case (idx)
            REG_MIN:  min_q  = data;
            REG_MAX:  max_q  = data;
            REG_RATE: rate_q = data;
            default:  mode_q = data[2:0];
        endcase
    endtask

    task automatic reconfigure(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [15:0] rate, input logic [2:0] mode);
        wait_idle();
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, hi);
        write_reg(REG_RATE, rate);
        write_reg(REG_MODE, 16'(mode));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          lo, hi, width, tmp, n, target;
        logic [2:0]  mode;
        logic [15:0] rate;

        // register defaults and cleared sweep state
        min_q     = 16'h0000;
        max_q     = 16'hFFFF;
        rate_q    = 16'h0000;
        mode_q    = MODE_OFF;
        cur_val   = '0;
        step_q    = '0;
        period_q  = '0;
        elapsed_q = '0;
        halted_q  = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, sweep off, value extremes, unused code
        push_item(ACT_TICK, 16'h0000);
        push_item(ACT_LOAD, 16'hFFFF);
        push_item(ACT_LOAD, 16'h0000);
        push_item(ACT_UNUSED, 16'hFFFF);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);

        // full range at top rate: step of five each tick, wrap at the top halts
        reconfigure(16'h0000, 16'hFFFF, 16'hFFFF, MODE_UP);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);
        push_item(ACT_TICK, 16'h0000);
        push_item(ACT_LOAD, 16'hFFFD);
        push_item(ACT_TICK, 16'h0000);
        push_item(ACT_TICK, 16'h0000);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);

        // zero range
        reconfigure(16'h0000, 16'h0000, 16'hFFFF, MODE_DN);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);

        // inverted range at the slowest rate
        reconfigure(16'd500, 16'd100, 16'd1, MODE_DN_UP);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);

        // zero rate leaves the step alone
        reconfigure(16'h0000, 16'hFFFF, 16'h0000, MODE_UP_DN);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);

        // reserved mode behaves as off
        reconfigure(16'h0000, 16'hFFFF, 16'hFFFF, MODE_RESERVED);
        push_item(ACT_RECOMPUTE, 16'h0000);
        push_item(ACT_TICK, 16'h0000);

        target = items_queued + RANDOM_ITEMS;
        while (items_queued < target) begin
            // idle profile by progress: sender light/receiver heavy, swapped, none
            tmp = RANDOM_ITEMS - (target - items_queued);
            if (tmp < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 20;
                rx_idle_pct = 83;
            end else if (tmp < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 83;
                rx_idle_pct = 20;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if ($urandom_range(4) == 0) begin
                // unconstrained settings, extremes likely
                case ($urandom_range(3))
                    0:       rate = 16'h0000;
                    1:       rate = 16'h0001;
                    2:       rate = 16'hFFFF;
                    default: rate = 16'($urandom);
                endcase
                reconfigure(edge_u16(), edge_u16(), rate, 3'($urandom_range(7)));
                push_item(ACT_RECOMPUTE, 16'($urandom));
                n = $urandom_range(15, 30);
                repeat (n) push_mixed_item(0, 65535);
            end else begin
                // wide span at a high rate gives a small step and a period of one or two ticks
                mode = 3'($urandom_range(MODE_UP, MODE_DN_UP));
                rate = 16'($urandom_range(15259, 65535));
                lo   = $urandom_range(0, 20000);
                hi   = $urandom_range(lo + 30000, 65535);
                reconfigure(16'(lo), 16'(hi), rate, mode);
                push_item(ACT_RECOMPUTE, 16'($urandom));

                // then a narrow window so the extents come up every few ticks
                width = $urandom_range(0, 80);
                case ($urandom_range(7))
                    0:       lo = 0;
                    1:       lo = 65535 - width;
                    default: lo = $urandom_range(0, 65535 - width);
                endcase
                hi = lo + width;
                if ($urandom_range(9) == 0) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if ($urandom_range(4) == 0) mode = 3'($urandom_range(7));
                if ($urandom_range(19) == 0) rate = 16'h0000;
                reconfigure(16'(lo), 16'(hi), rate, mode);
                if (lo > hi) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                push_item(ACT_LOAD, 16'($urandom_range(lo, hi)));
                n = $urandom_range(25, 50);
                repeat (n) push_mixed_item(lo, hi);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("checked %0d results over %0d register settings", results_checked,
                 settings_used);
        $display("seen %0d recomputes, %0d steps and %0d extent events", recomputes_seen,
                 steps_seen, ends_seen);
        if (error_count == 0) begin
            $display("parameter_sweep_engine regression: pass");
        end else begin
            $display("parameter_sweep_engine regression: fail");
        end
        $finish;
    end

endmodule

/* parameter_sweep_engine.f */
rtl/pse_pkg.sv
rtl/pse_div.sv
rtl/pse_ctrl.sv
rtl/pse_datapath.sv
rtl/parameter_sweep_engine.sv
rtl/pse_checker.sv
verif/parameter_sweep_engine_tb.sv
